>>> hw/rtl/cxaj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cxaj_pkg
// Shared widths, register map and helpers for the ring automaton jump block.
// ----------------------------------------------------------------------------
package cxaj_pkg;

	localparam int LIGHT_W = 64;
	localparam int LEN_W   = 7;
	localparam int ROT_W   = 6;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// register index taken from paddr[2]
	localparam logic REG_RING_LENGTH = 1'b0;

	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [LIGHT_W-1:0] mask;
		logic               derive;
	} cfg_t;

	function automatic logic [LIGHT_W-1:0] lane_mask(input logic [LEN_W-1:0] len);
		logic [LIGHT_W-1:0] m;
		begin
			if (len >= LEN_W'(LIGHT_W)) begin
				m = '1;
			end else begin
				m = (LIGHT_W'(1) << len) - LIGHT_W'(1);
			end
			return m;
		end
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cxaj_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cxaj_cfg
// Ring length register on the apb port and the table rebuild counter.
// ----------------------------------------------------------------------------
module cxaj_cfg import cxaj_pkg::*; #(
	parameter int RING_MAX  = 64,
	parameter int STEP_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	localparam int CNT_W = $clog2(STEP_BITS + 1);

	logic [LEN_W-1:0]   len_q;
	logic [LIGHT_W-1:0] mask_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               wr_en;
	logic [LEN_W-1:0]   wr_len;

	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RING_LENGTH);
	assign pready = 1'b1;

	// zero reads as one, large values saturate
	always_comb begin
		wr_len = pwdata[LEN_W-1:0];
		if (wr_len == '0) begin
			wr_len = LEN_W'(1);
		end
		if (wr_len > LEN_W'(RING_MAX)) begin
			wr_len = LEN_W'(RING_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(RING_MAX);
			mask_q <= lane_mask(LEN_W'(RING_MAX));
			cnt_q  <= CNT_W'(STEP_BITS);
		end else if (wr_en) begin
			len_q  <= wr_len;
			mask_q <= lane_mask(wr_len);
			cnt_q  <= CNT_W'(STEP_BITS);
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RING_LENGTH) begin
			prdata = DATA_W'(len_q);
		end
	end

	assign cfg.len    = len_q;
	assign cfg.mask   = mask_q;
	assign cfg.derive = (cnt_q != '0);

endmodule
`default_nettype wire

>>> hw/rtl/cxaj_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cxaj_cell
// One step-count bit: holds 2^j mod length and applies a conditional
// rotate-xor to the ring passing through.
// ----------------------------------------------------------------------------
module cxaj_cell import cxaj_pkg::*; #(
	parameter int STEP_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  cfg_t                      cfg,
	input  wire logic [ROT_W-1:0]     rot_prev,
	input  wire logic                 double_en,
	output logic      [ROT_W-1:0]     rot,
	input  wire logic                 in_valid,
	input  wire logic [LIGHT_W-1:0]   in_x,
	input  wire logic [STEP_BITS-1:0] in_steps,
	output logic                      out_valid,
	output logic      [LIGHT_W-1:0]   out_x,
	output logic      [STEP_BITS-1:0] out_steps
);

	logic [ROT_W-1:0]   rot_q;
	logic [LEN_W-1:0]   cand;
	logic [LEN_W-1:0]   rot_next;
	logic [LEN_W-1:0]   back;
	logic [LIGHT_W-1:0] up;
	logic [LIGHT_W-1:0] down;
	logic [LIGHT_W-1:0] rot_x;
	logic               valid_q;
	logic [LIGHT_W-1:0] x_q;
	logic [STEP_BITS-1:0] steps_q;

	// rotation of this cell follows from the left neighbor, one compare-subtract
	always_comb begin
		cand = double_en ? {rot_prev, 1'b0} : {1'b0, rot_prev};
		rot_next = (cand >= cfg.len) ? (cand - cfg.len) : cand;
	end

	always_ff @(posedge clk) begin
		if (cfg.derive) begin
			rot_q <= rot_next[ROT_W-1:0];
		end
	end

	assign rot = rot_q;

	// rotate up inside the ring; zero rotation gives x itself, so x ^ x clears
	always_comb begin
		back  = cfg.len - {1'b0, rot_q};
		up    = in_x << rot_q;
		down  = in_x >> back;
		rot_x = (rot_q == '0) ? in_x : ((up | down) & cfg.mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q     <= in_steps[0] ? (in_x ^ rot_x) : in_x;
		steps_q <= in_steps >> 1;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_steps = steps_q;

endmodule
`default_nettype wire

>>> hw/rtl/circular_xor_automaton_jump.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_xor_automaton_jump
// Jumps a ring of lights ahead by a step count under new[i] = old[i]^old[i-1].
// ----------------------------------------------------------------------------
// Usage:
//   A transfer is taken on start while busy is low: initial_lights and
//   step_count go into a row of STEP_BITS cells, one per step-count bit.
//   Each cell holds 2^j mod ring_length and applies a rotate-xor when its bit
//   is set, then hands the ring to the next cell.
//   The done strobe comes out of the last cell register; one transfer can
//   enter every cycle while busy is low. final_lights is valid only in the
//   cycle of done, and the receiver has to take it then.
//   Writing ring_length (apb, byte address 0) rebuilds the rotation values:
//   they ripple down the row, and busy stays high after the write while the
//   rebuild counter runs down. After reset the length is RING_MAX and busy is
//   likewise high. Lights at or above the ring length are ignored on
//   input and read as zero on output.
// ----------------------------------------------------------------------------
module circular_xor_automaton_jump import cxaj_pkg::*; #(
	parameter int RING_MAX  = 64,
	parameter int STEP_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]    prdata,
	output logic                      pready,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [LIGHT_W-1:0]   initial_lights,
	input  wire logic [STEP_BITS-1:0] step_count,
	output logic                      done,
	output logic      [LIGHT_W-1:0]   final_lights
);

	cfg_t cfg;

	logic [ROT_W-1:0]     rot_chain   [STEP_BITS+1];
	logic                 valid_chain [STEP_BITS+1];
	logic [LIGHT_W-1:0]   x_chain     [STEP_BITS+1];
	logic [STEP_BITS-1:0] steps_chain [STEP_BITS+1];

	cxaj_cfg #(
		.RING_MAX  (RING_MAX),
		.STEP_BITS (STEP_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = cfg.derive;

	// first cell reduces 1 mod length, the rest double their neighbor
	assign rot_chain[0]   = ROT_W'(1);
	assign valid_chain[0] = start && !busy;
	assign x_chain[0]     = initial_lights & cfg.mask;
	assign steps_chain[0] = step_count;

	for (genvar j = 0; j < STEP_BITS; j++) begin : g_cell
		cxaj_cell #(
			.STEP_BITS (STEP_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.rot_prev  (rot_chain[j]),
			.double_en ((j != 0)),
			.rot       (rot_chain[j+1]),
			.in_valid  (valid_chain[j]),
			.in_x      (x_chain[j]),
			.in_steps  (steps_chain[j]),
			.out_valid (valid_chain[j+1]),
			.out_x     (x_chain[j+1]),
			.out_steps (steps_chain[j+1])
		);
	end

	assign done         = valid_chain[STEP_BITS];
	assign final_lights = x_chain[STEP_BITS];

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Ring automaton jump-ahead block: a directed table, then random phases under
// several ring lengths. Each result is checked against its table entry or an in-bench model.
// ----------------------------------------------------------------------------
module tb;
	import cxaj_pkg::*;

	localparam int RING_MAX    = 64;
	localparam int STEP_BITS   = 32;
	localparam int ROWS        = 24;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 140;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [ADDR_W-1:0] ADDR_RING  = {REG_RING_LENGTH, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_SPARE = {~REG_RING_LENGTH, 2'b00};

	typedef struct packed {
		bit                    do_cfg;
		logic [ADDR_W-1:0]     cfg_addr;
		logic [DATA_W-1:0]     cfg_data;
		logic [LIGHT_W-1:0]    lights;
		logic [STEP_BITS-1:0]  steps;
		bit                    known;
		logic [LIGHT_W-1:0]    want;
	} ring_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	wire  [DATA_W-1:0]    prdata;
	wire                  pready;
	logic                 start = 1'b0;
	wire                  busy;
	logic [LIGHT_W-1:0]   initial_lights = '0;
	logic [STEP_BITS-1:0] step_count = '0;
	wire                  done;
	wire  [LIGHT_W-1:0]   final_lights;

	// in-bench copy of the ring setting and the per-stage rotations
	logic [LEN_W-1:0] ring_len;
	logic [ROT_W-1:0] hop [STEP_BITS];

	logic [LIGHT_W-1:0] lights_due [$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int quiet = 0;
	bit idle_on = 1'b1;

	ring_row_t dir_rows [ROWS] = '{
		// reset length 64
		'{1'b0, ADDR_RING, 32'd0, 64'h0, 32'hffff_ffff, 1'b1, 64'h0},
		'{1'b0, ADDR_RING, 32'd0, '1, 32'h0, 1'b1, '1},
		'{1'b0, ADDR_RING, 32'd0, 64'h1, 32'h1, 1'b1, 64'h3},
		'{1'b0, ADDR_RING, 32'd0, 64'h8000_0000_0000_0000, 32'h1, 1'b1,
			64'h8000_0000_0000_0001},
		'{1'b0, ADDR_RING, 32'd0, '1, 32'h1, 1'b1, 64'h0},
		'{1'b0, ADDR_RING, 32'd0, 64'h0123_4567_89ab_cdef, 32'h40, 1'b1, 64'h0},
		'{1'b0, ADDR_RING, 32'd0, 64'h5a5a_5a5a_5a5a_5a5a, 32'h8000_0000, 1'b1, 64'h0},
		'{1'b0, ADDR_RING, 32'd0, 64'h0123_4567_89ab_cdef, 32'h7, 1'b0, 64'h0},
		// zero length reads as a single light
		'{1'b1, ADDR_RING, 32'd0, 64'h1, 32'h0, 1'b1, 64'h1},
		'{1'b0, ADDR_RING, 32'd0, 64'h1, 32'h1, 1'b1, 64'h0},
		'{1'b0, ADDR_RING, 32'd0, '1, 32'h0, 1'b1, 64'h1},
		'{1'b0, ADDR_RING, 32'd0, 64'hffff_ffff_ffff_fffe, 32'hffff_ffff, 1'b1, 64'h0},
		// oversize lengths saturate
		'{1'b1, ADDR_RING, 32'd127, '1, 32'h0, 1'b1, '1},
		'{1'b1, ADDR_RING, 32'd65, 64'h1, 32'h1, 1'b1, 64'h3},
		'{1'b1, ADDR_RING, 32'd2, '1, 32'h0, 1'b1, 64'h3},
		'{1'b0, ADDR_RING, 32'd0, 64'h1, 32'h1, 1'b1, 64'h3},
		'{1'b1, ADDR_RING, 32'd3, 64'h1, 32'h1, 1'b1, 64'h3},
		'{1'b0, ADDR_RING, 32'd0, 64'h5, 32'hffff_ffff, 1'b0, 64'h0},
		'{1'b1, ADDR_RING, 32'd63, '1, 32'h1, 1'b1, 64'h0},
		'{1'b0, ADDR_RING, 32'd0, 64'h4000_0000_0000_0000, 32'h1, 1'b1,
			64'h4000_0000_0000_0001},
		'{1'b0, ADDR_RING, 32'd0, 64'hdead_beef_cafe_f00d, 32'hdead_beef, 1'b0, 64'h0},
		// only the low seven data bits count
		'{1'b1, ADDR_RING, 32'hffff_ff85, '1, 32'h0, 1'b1, 64'h1f},
		// a write to the unused index leaves the length alone
		'{1'b1, ADDR_SPARE, 32'd1, '1, 32'h0, 1'b1, 64'h1f},
		'{1'b0, ADDR_RING, 32'd0, 64'hfedc_ba98_7654_3210, 32'hffff_ffff, 1'b0, 64'h0}
	};

	circular_xor_automaton_jump #(
		.RING_MAX(RING_MAX),
		.STEP_BITS(STEP_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.initial_lights(initial_lights),
		.step_count(step_count),
		.done(done),
		.final_lights(final_lights)
	);

	always #5 clk = ~clk;

	function automatic void set_ring(input logic [DATA_W-1:0] value);
		int n;
		int r;
		n = int'(value[LEN_W-1:0]);
		if (n < 1) begin
			n = 1;
		end
		if (n > RING_MAX) begin
			n = RING_MAX;
		end
		ring_len = LEN_W'(n);
		r = 1 % n;
		for (int j = 0; j < STEP_BITS; j++) begin
			hop[j] = ROT_W'(r);
			r = (r * 2) % n;
		end
	endfunction

	// one conditional rotate-xor per step-count bit, inside the ring
	function automatic logic [LIGHT_W-1:0] jump_ring(input logic [LIGHT_W-1:0] lights,
			input logic [STEP_BITS-1:0] steps);
		logic [LIGHT_W-1:0] keep;
		logic [LIGHT_W-1:0] x;
		logic [LIGHT_W-1:0] turned;
		int n;
		int r;
		n = int'(ring_len);
		keep = (n >= LIGHT_W) ? '1 : ((LIGHT_W'(1) << n) - LIGHT_W'(1));
		x = lights & keep;
		for (int j = 0; j < STEP_BITS; j++) begin
			if (steps[j]) begin
				r = int'(hop[j]);
				// zero rotation: the ring cancels itself out
				turned = (r == 0) ? x : (((x << r) | (x >> (n - r))) & keep);
				x = x ^ turned;
			end
		end
		return x & keep;
	endfunction

	task automatic send_lights(input logic [LIGHT_W-1:0] lights,
			input logic [STEP_BITS-1:0] steps, input bit known,
			input logic [LIGHT_W-1:0] want);
		if (idle_on && $urandom_range(99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		initial_lights <= lights;
		step_count <= steps;
		do @(posedge clk); while (busy);
		lights_due.push_back(known ? want : jump_ring(lights, steps));
		items_sent++;
	endtask

	// register writes only once every pending result is back
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		start <= 1'b0;
		do @(posedge clk); while (lights_due.size() != 0);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_RING) begin
			set_ring(data);
		end
		cfg_writes++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lights_due.size() == 0) begin
				$error("final_lights: no result expected, actual %h", final_lights);
				errors++;
			end else begin
				if (final_lights !== lights_due[0]) begin
					$error("final_lights: expected %h actual %h", lights_due[0],
						final_lights);
					errors++;
				end
				void'(lights_due.pop_front());
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		while (quiet < QUIET_LIMIT) @(posedge clk);
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("tb: errors");
		$finish;
	end

	initial begin
		logic [LIGHT_W-1:0]   l;
		logic [STEP_BITS-1:0] s;
		logic [DATA_W-1:0]    cfg;
		set_ring(DATA_W'(RING_MAX));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < ROWS; i++) begin
			if (dir_rows[i].do_cfg) begin
				write_reg(dir_rows[i].cfg_addr, dir_rows[i].cfg_data);
			end
			send_lights(dir_rows[i].lights, dir_rows[i].steps, dir_rows[i].known,
				dir_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					cfg = 32'd1;
				end
				1: begin
					cfg = DATA_W'(RING_MAX);
				end
				2: begin
					cfg = 32'd127;
				end
				3: begin
					cfg = 32'd0;
				end
				default: begin
					cfg = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, RING_MAX);
				end
			endcase
			if (p % 4 == 2) begin
				write_reg(ADDR_SPARE, $urandom);
			end
			write_reg(ADDR_RING, cfg);
			// one phase runs back to back
			idle_on = (p != 5);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(9))
					0: begin
						l = '0;
					end
					1: begin
						l = '1;
					end
					2: begin
						l = LIGHT_W'(1) << $urandom_range(LIGHT_W - 1);
					end
					default: begin
						l = {$urandom, $urandom};
					end
				endcase
				case ($urandom_range(9))
					0: begin
						s = '0;
					end
					1: begin
						s = '1;
					end
					2: begin
						s = STEP_BITS'(1) << $urandom_range(STEP_BITS - 1);
					end
					3: begin
						s = STEP_BITS'($urandom_range(300));
					end
					default: begin
						s = STEP_BITS'($urandom);
					end
				endcase
				send_lights(l, s, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (lights_due.size() != 0) @(posedge clk);
		repeat (STEP_BITS + 8) @(posedge clk);
		$display("run: %0d light rings jumped, %0d results checked", items_sent,
			results_seen);
		$display("run: %0d register writes, ring lengths 1 through %0d", cfg_writes,
			RING_MAX);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/cxaj_pkg.sv
hw/rtl/cxaj_cfg.sv
hw/rtl/cxaj_cell.sv
hw/rtl/circular_xor_automaton_jump.sv
dv/tb.sv
